// ===== src/garch_variance_recursion_assert.svh =====
// assertion macros for the garch variance recursion block
// included by the top level; no other dependencies
`ifndef GARCH_VARIANCE_RECURSION_ASSERT_SVH
`define GARCH_VARIANCE_RECURSION_ASSERT_SVH
`ifndef SYNTHESIS
`define GVR_ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define GVR_ASSERT_NEXT(label, clk, rstn, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) \
        else $error("assertion failed");
`else
`define GVR_ASSERT_IMPL(label, clk, rstn, prop)
`define GVR_ASSERT_NEXT(label, clk, rstn, cond, nxt)
`endif
`endif

// ===== src/gvr_pkg.sv =====
// shared types and constants for the garch variance recursion block
// no dependencies
package gvr_pkg;
    localparam logic [2:0] REG_OMEGA   = 3'd0;
    localparam logic [2:0] REG_ARCH1   = 3'd1;
    localparam logic [2:0] REG_ARCH2   = 3'd2;
    localparam logic [2:0] REG_ARCH3   = 3'd3;
    localparam logic [2:0] REG_GARCH1  = 3'd4;
    localparam logic [2:0] REG_GARCH2  = 3'd5;
    localparam logic [2:0] REG_GARCH3  = 3'd6;
    localparam logic [2:0] REG_BURN    = 3'd7;
    localparam logic [15:0] BURN_RESET = 16'd500;
    localparam logic [16:0] COUNT_MAX  = 17'h1FFFF;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_START = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_MAC   = 8'b0000_1000,
        ST_SQRT  = 8'b0001_0000,
        ST_MUL   = 8'b0010_0000,
        ST_DONE  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;
endpackage

// ===== src/garch_variance_recursion.sv =====
// top level of the garch variance recursion block
// depends on gvr_pkg and garch_variance_recursion_assert.svh
// One innovation per request. The block is not ready while a request is at work, nor
// while its result waits for the output register to drain. The first step of a run
// runs a 40-step restoring divide for the unconditional variance. When persistence is
// one or more the start value is omega times ten instead. The other start steps of a run
// reuse the start value. A recursion step runs its products through one shared 32x32
// multiplier; each ARCH term then takes a narrow coefficient multiply on its registered
// square. Every step ends with a bit-pair square root and one multiply for the series
// value. Results wait in the output register until taken. Burn-in steps update history
// but produce no result.
`include "garch_variance_recursion_assert.svh"
module garch_variance_recursion #(
    parameter int ARCH_ORDER  = 2,
    parameter int GARCH_ORDER = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_innovation,
    input  logic               s_start_run,
    input  logic               s_last_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_series_value,
    output logic        [31:0] m_cond_variance,
    output logic        [23:0] m_cond_stddev,
    output logic               m_last_output,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [2:0]  cfg_index,
    input  logic        [31:0] cfg_data
);
    localparam int AO = ARCH_ORDER < 0 ? 0 : (ARCH_ORDER > 3 ? 3 : ARCH_ORDER);
    localparam int GO = GARCH_ORDER < 0 ? 0 : (GARCH_ORDER > 3 ? 3 : GARCH_ORDER);
    localparam int MAXPQ = AO > GO ? AO : GO;
    localparam int NTERM = AO + GO;

    // configuration registers
    logic [23:0] omega_reg;
    logic [15:0] arch_reg [3];
    logic [15:0] garch_reg [3];
    logic [15:0] burn_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            omega_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                arch_reg[i]  <= '0;
                garch_reg[i] <= '0;
            end
            burn_reg <= gvr_pkg::BURN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                gvr_pkg::REG_OMEGA:  omega_reg    <= cfg_data[23:0];
                gvr_pkg::REG_ARCH1:  arch_reg[0]  <= cfg_data[15:0];
                gvr_pkg::REG_ARCH2:  arch_reg[1]  <= cfg_data[15:0];
                gvr_pkg::REG_ARCH3:  arch_reg[2]  <= cfg_data[15:0];
                gvr_pkg::REG_GARCH1: garch_reg[0] <= cfg_data[15:0];
                gvr_pkg::REG_GARCH2: garch_reg[1] <= cfg_data[15:0];
                gvr_pkg::REG_GARCH3: garch_reg[2] <= cfg_data[15:0];
                gvr_pkg::REG_BURN:   burn_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // persistence, sum of coefficients in use
    logic [18:0] pers;
    always_comb begin
        pers = '0;
        for (int i = 0; i < 3; i++) begin
            if (i < AO) pers = pers + {3'd0, arch_reg[i]};
            if (i < GO) pers = pers + {3'd0, garch_reg[i]};
        end
    end

    gvr_pkg::state_t state_reg;
    logic [31:0] po_reg [3];
    logic [31:0] pv_reg [3];
    logic [31:0] start_reg;
    logic [16:0] count_reg;
    logic [15:0] emag_reg;
    logic        neg_reg, last_reg, emit_reg;
    logic [31:0] var_reg;
    logic [49:0] acc_reg;
    logic [5:0]  step_reg;
    // divider
    logic [39:0] quo_reg;
    logic [17:0] rem_reg;
    logic [16:0] den_reg;
    // square root
    logic [47:0] sq_v_reg;
    logic [49:0] sq_rem_reg;
    logic [23:0] sq_root_reg;

    // shared multiplier operands
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [2:0]  ti;
    always_comb begin
        ti = step_reg[2:0];
        mul_a = '0;
        mul_b = '0;
        if (state_reg == gvr_pkg::ST_MAC) begin
            if (32'(ti) < 32'(AO)) begin
                mul_a = po_reg[ti[1:0]][31] ? (~po_reg[ti[1:0]] + 32'd1)
                                             : po_reg[ti[1:0]];
                mul_b = mul_a;
            end else begin
                mul_a = pv_reg[2'(ti - 3'(AO))];
                mul_b = {16'd0, garch_reg[2'(ti - 3'(AO))]};
            end
        end else if (state_reg == gvr_pkg::ST_MUL) begin
            mul_a = {16'd0, emag_reg};
            mul_b = {8'd0, sq_root_reg};
        end
    end
    assign prod = mul_a * mul_b;

    // arch square register, second multiply next cycle
    logic        sq_phase_reg;
    logic [47:0] sq_hold_reg;
    logic [63:0] ap;
    logic [2:0]  ai;
    assign ai = step_reg[2:0];
    assign ap = {16'd0, sq_hold_reg} * {48'd0, arch_reg[ai[1:0]]};

    logic [49:0] sq_trial;
    assign sq_trial = {sq_rem_reg[47:0], sq_v_reg[47:46]} - {24'd0, sq_root_reg, 2'b01};
    logic [18:0] div_trial;
    assign div_trial = {rem_reg, quo_reg[39]} - {2'd0, den_reg};

    logic [31:0] sat_var;
    assign sat_var = acc_reg[49:32] != 18'd0 ? 32'hFFFFFFFF : acc_reg[31:0];
    logic [40:0] smag;
    logic [31:0] series_w;
    always_comb begin
        smag = (41'(prod[39:0]) + 41'd2048) >> 12;
        if (neg_reg) begin
            if (smag > 41'h80000000) smag = 41'h80000000;
            series_w = 32'(~smag[31:0] + 32'd1);
        end else begin
            if (smag > 41'h7FFFFFFF) smag = 41'h7FFFFFFF;
            series_w = smag[31:0];
        end
    end

    assign s_ready = state_reg == gvr_pkg::ST_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gvr_pkg::ST_IDLE;
            m_valid   <= 1'b0;
            count_reg <= '0;
            start_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                po_reg[i] <= '0;
                pv_reg[i] <= '0;
            end
            step_reg     <= '0;
            sq_phase_reg <= 1'b0;
        end else begin
            case (state_reg)
                gvr_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        emag_reg <= s_innovation[15] ? 16'(-s_innovation) : s_innovation;
                        neg_reg  <= s_innovation[15];
                        last_reg <= s_last_sample;
                        if (s_start_run) begin
                            count_reg <= '0;
                            for (int i = 0; i < 3; i++) begin
                                po_reg[i] <= '0;
                                pv_reg[i] <= '0;
                            end
                        end
                        state_reg <= gvr_pkg::ST_START;
                    end
                end
                gvr_pkg::ST_START: begin
                    emit_reg <= count_reg >= {1'b0, burn_reg};
                    step_reg <= '0;
                    sq_phase_reg <= 1'b0;
                    acc_reg  <= {26'd0, omega_reg};
                    if (count_reg == '0) begin
                        if (pers < 19'd65536) begin
                            quo_reg   <= {omega_reg, 16'd0};
                            rem_reg   <= '0;
                            den_reg   <= 17'(19'd65536 - pers);
                            state_reg <= gvr_pkg::ST_DIV;
                        end else begin
                            start_reg <= 32'({4'd0, omega_reg, 3'd0} + {6'd0, omega_reg, 1'd0});
                            var_reg   <= 32'({4'd0, omega_reg, 3'd0} + {6'd0, omega_reg, 1'd0});
                            state_reg <= gvr_pkg::ST_SQRT;
                        end
                    end else if (count_reg < 17'(MAXPQ)) begin
                        var_reg   <= start_reg;
                        state_reg <= gvr_pkg::ST_SQRT;
                    end else if (NTERM == 0) begin
                        var_reg   <= {8'd0, omega_reg};
                        state_reg <= gvr_pkg::ST_SQRT;
                    end else begin
                        state_reg <= gvr_pkg::ST_MAC;
                    end
                    sq_root_reg <= '0;
                    sq_rem_reg  <= '0;
                end
                // restoring divide, one quotient bit a cycle
                gvr_pkg::ST_DIV: begin
                    if (!div_trial[18]) begin
                        rem_reg <= div_trial[17:0];
                        quo_reg <= {quo_reg[38:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[16:0], quo_reg[39]};
                        quo_reg <= {quo_reg[38:0], 1'b0};
                    end
                    if (step_reg == 6'd39) begin
                        step_reg  <= '0;
                        state_reg <= gvr_pkg::ST_DONE;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                // finish divide: saturate and hold as start variance
                gvr_pkg::ST_DONE: begin
                    start_reg <= quo_reg[39:32] != 8'd0 ? 32'hFFFFFFFF : quo_reg[31:0];
                    var_reg   <= quo_reg[39:32] != 8'd0 ? 32'hFFFFFFFF : quo_reg[31:0];
                    state_reg <= gvr_pkg::ST_SQRT;
                end
                // one product a cycle for garch terms; an arch term squares first, then multiplies by its coefficient
                gvr_pkg::ST_MAC: begin
                    if (32'(ti) < 32'(AO) && !sq_phase_reg) begin
                        sq_hold_reg  <= prod[63:16];
                        sq_phase_reg <= 1'b1;
                    end else begin
                        if (32'(ti) < 32'(AO))
                            acc_reg <= acc_reg + 50'(ap[63:16]);
                        else
                            acc_reg <= acc_reg + 50'(prod[63:16]);
                        sq_phase_reg <= 1'b0;
                        if (32'(ti) == 32'(NTERM - 1)) begin
                            step_reg  <= '0;
                            state_reg <= gvr_pkg::ST_OUT;
                        end else begin
                            step_reg <= step_reg + 6'd1;
                        end
                    end
                end
                gvr_pkg::ST_OUT: begin
                    var_reg   <= sat_var;
                    state_reg <= gvr_pkg::ST_SQRT;
                    sq_root_reg <= '0;
                    sq_rem_reg  <= '0;
                end
                // bit-pair square root of var << 16
                gvr_pkg::ST_SQRT: begin
                    if (step_reg == 6'd0 && sq_root_reg == '0 && sq_rem_reg == '0
                        && !sq_phase_reg) begin
                        sq_v_reg     <= {var_reg, 16'd0};
                        sq_phase_reg <= 1'b1;
                    end else begin
                        if (!sq_trial[49]) begin
                            sq_rem_reg  <= sq_trial;
                            sq_root_reg <= {sq_root_reg[22:0], 1'b1};
                        end else begin
                            sq_rem_reg  <= {sq_rem_reg[47:0], sq_v_reg[47:46]};
                            sq_root_reg <= {sq_root_reg[22:0], 1'b0};
                        end
                        sq_v_reg <= {sq_v_reg[45:0], 2'b00};
                        if (step_reg == 6'd23) begin
                            step_reg     <= '0;
                            sq_phase_reg <= 1'b0;
                            state_reg    <= gvr_pkg::ST_MUL;
                        end else begin
                            step_reg <= step_reg + 6'd1;
                        end
                    end
                end
                // series value, update or clear history and output
                gvr_pkg::ST_MUL: begin
                    if (!m_valid || m_ready) begin
                        if (last_reg) begin
                            count_reg <= '0;
                            for (int i = 0; i < 3; i++) begin
                                po_reg[i] <= '0;
                                pv_reg[i] <= '0;
                            end
                        end else begin
                            po_reg[2] <= po_reg[1];
                            po_reg[1] <= po_reg[0];
                            po_reg[0] <= series_w;
                            pv_reg[2] <= pv_reg[1];
                            pv_reg[1] <= pv_reg[0];
                            pv_reg[0] <= var_reg;
                            if (count_reg < gvr_pkg::COUNT_MAX)
                                count_reg <= count_reg + 17'd1;
                        end
                        m_valid         <= emit_reg;
                        m_series_value  <= series_w;
                        m_cond_variance <= var_reg;
                        m_cond_stddev   <= sq_root_reg;
                        m_last_output   <= last_reg;
                        state_reg       <= gvr_pkg::ST_IDLE;
                    end
                end
                default: state_reg <= gvr_pkg::ST_IDLE;
            endcase
            if (m_valid && m_ready && state_reg != gvr_pkg::ST_MUL) m_valid <= 1'b0;
        end
    end

    // checks
    `GVR_ASSERT_IMPL(a_onehot, aclk, aresetn, $onehot(state_reg))
    `GVR_ASSERT_NEXT(a_accept, aclk, aresetn, s_valid && s_ready, state_reg == gvr_pkg::ST_START)
    `GVR_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_series_value))
endmodule
